FILE: sv/swsd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sliding-window standard deviation block.
// No dependencies; imported by the top, square-root and divider modules (not by the RAM).
package swsd_pkg;

    // Fixed field widths of the stream and configuration ports, and window length limits
    parameter int STD_W      = 23;
    parameter int HELD_W     = 9;
    parameter int CFG_W      = 9;
    parameter int WIN_MIN    = 2;
    parameter int WIN_RESET  = 16;
    // radicand is scaled by 2^16 so the root carries 8 fraction bits
    parameter int FRAC_SHIFT = 16;

    localparam logic [STD_W-1:0] STD_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_ACCUM,
        S_MUL,
        S_DIFF,
        S_ROOT_GO,
        S_ROOT_WAIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } t_state;

    // status of a multi-cycle arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

FILE: sv/sliding_window_std_dev_top.sv
`timescale 1ns / 1ps
// Sliding-window standard deviation: sample ring in RAM, running sums, bit-serial root/divide.
// Each item passes read, accumulate, multiply, difference, root and divide states before the
//   result register loads; root and divide are skipped while fewer than two samples are held.
// A new item is accepted only in the idle state, after the previous result has been loaded;
//   the bit-serial square-root unit and divider keep the block busy until they finish.
// Reset (synchronous, active low): window 16 (capped at MAX_WINDOW), ring empty, sums zero;
//   the RAM is not cleared, since the fill count keeps unwritten entries from ever being read.
// Depends on swsd_pkg, swsd_ram, swsd_isqrt, swsd_div.
module sliding_window_std_dev_top #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wen,
    input  logic [swsd_pkg::CFG_W-1:0]            i_cfg_wdata,    // window_length
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      i_s_axis_tdata, // sample
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [((swsd_pkg::STD_W+swsd_pkg::HELD_W+7)/8)*8-1:0]
                                                  o_m_axis_tdata  // std_dev, samples_held
);
    import swsd_pkg::*;

    localparam int ADDR_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
    localparam int OUT_TD_W = ((STD_W + HELD_W + 7) / 8) * 8;
    localparam int SUM_W    = SAMPLE_BITS + CNT_W;
    localparam int SQ1_W    = 2 * SAMPLE_BITS;
    localparam int SQ_W     = 2 * SAMPLE_BITS + CNT_W - 1;
    localparam int D_W      = 2 * SUM_W;
    localparam int R_W      = ((D_W + FRAC_SHIFT + 1) / 2) * 2;
    localparam int ROOT_W   = R_W / 2;
    localparam int CMP_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int QE_W     = (ROOT_W > STD_W) ? ROOT_W : STD_W;
    localparam int HE_W     = (CNT_W > HELD_W) ? CNT_W : HELD_W;
    localparam int WIN_RST  = (WIN_RESET > MAX_WINDOW) ? MAX_WINDOW : WIN_RESET;

    t_state r_state, n_state;

    logic [CNT_W-1:0]              r_window;
    logic [ADDR_W-1:0]             r_pos;
    logic [CNT_W-1:0]              r_fill;
    logic signed [SUM_W-1:0]       r_sum;
    logic [SQ_W-1:0]               r_sumsq;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_old;
    logic [SQ1_W-1:0]              r_sq_old;
    logic [SQ1_W-1:0]              r_sq_new;
    logic [D_W-1:0]                r_a;
    logic [D_W-1:0]                r_b;
    logic [R_W-1:0]                r_rad;
    logic                          r_small;
    logic                          r_out_valid;
    logic [STD_W-1:0]              r_out_std;
    logic [HELD_W-1:0]             r_out_held;

    // control
    logic in_acc;
    logic out_free;
    logic in_ready;
    logic ram_we;
    logic sq_start;
    logic dv_start;
    logic out_load;

    // datapath
    logic [CMP_W-1:0]              cfg_ext;
    logic [CMP_W-1:0]              win_sat;
    logic [SAMPLE_BITS-1:0]        rd_data;
    logic                          full;
    logic signed [SAMPLE_BITS-1:0] old_smp;
    logic signed [SQ1_W-1:0]       sq_old_s;
    logic signed [SQ1_W-1:0]       sq_new_s;
    logic [CNT_W-1:0]              fill_next;
    logic [CNT_W-1:0]              pos_inc;
    logic [ADDR_W-1:0]             pos_next;
    logic [SUM_W-1:0]              sum_abs;
    logic [D_W-1:0]                a_prod;
    logic [D_W-1:0]                b_prod;
    logic [D_W-1:0]                diff;
    logic [ROOT_W-1:0]             sq_root;
    logic [ROOT_W-1:0]             dv_quot;
    logic [QE_W-1:0]               quot_ext;
    logic [STD_W-1:0]              std_sat;
    logic [HE_W-1:0]               held_ext;
    t_unit_stat                    sq_stat;
    t_unit_stat                    dv_stat;

    assign in_acc   = i_s_axis_tvalid && in_ready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    // ---------------- ring store ----------------
    swsd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos),
        .i_wdata (r_x),
        .i_raddr (r_pos),
        .o_rdata (rd_data)
    );

    // ---------------- arithmetic units ----------------
    swsd_isqrt #(
        .RAD_W (R_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (r_rad),
        .o_stat  (sq_stat),
        .o_root  (sq_root)
    );

    swsd_div #(
        .NUM_W (ROOT_W),
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   (sq_root),
        .i_den   (r_fill),
        .o_stat  (dv_stat),
        .o_quot  (dv_quot)
    );

    // ---------------- combinational datapath ----------------
    assign cfg_ext = CMP_W'(i_cfg_wdata);
    assign win_sat = (cfg_ext < CMP_W'(WIN_MIN))    ? CMP_W'(WIN_MIN) :
                     (cfg_ext > CMP_W'(MAX_WINDOW)) ? CMP_W'(MAX_WINDOW) : cfg_ext;

    // the oldest sample drops out only once the window is full
    assign full      = (r_fill >= r_window);
    assign old_smp   = full ? $signed(rd_data) : '0;
    assign sq_old_s  = old_smp * old_smp;
    assign sq_new_s  = r_x * r_x;
    assign fill_next = full ? r_window : (r_fill + CNT_W'(1));
    assign pos_inc   = CNT_W'(r_pos) + CNT_W'(1);
    assign pos_next  = (pos_inc >= r_window) ? '0 : pos_inc[ADDR_W-1:0];

    assign sum_abs = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign a_prod  = r_fill * r_sumsq;
    assign b_prod  = sum_abs * sum_abs;
    assign diff    = (r_a > r_b) ? (r_a - r_b) : '0;

    assign quot_ext = QE_W'(dv_quot);
    assign std_sat  = (quot_ext > QE_W'(STD_MAX)) ? STD_MAX : quot_ext[STD_W-1:0];
    assign held_ext = HE_W'(r_fill);

    // ---------------- control ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_READ;
                end
            end
            S_READ:    n_state = S_ACCUM;
            S_ACCUM:   n_state = S_MUL;
            S_MUL: begin
                if (r_fill < CNT_W'(2)) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF:    n_state = S_ROOT_GO;
            S_ROOT_GO: n_state = S_ROOT_WAIT;
            S_ROOT_WAIT: begin
                if (sq_stat.done) begin
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO:  n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (dv_stat.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        ram_we   = 1'b0;
        sq_start = 1'b0;
        dv_start = 1'b0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE:    in_ready = 1'b1;
            S_READ:    ram_we   = 1'b1;
            S_ROOT_GO: sq_start = 1'b1;
            S_DIV_GO:  dv_start = 1'b1;
            S_OUT:     out_load = out_free;
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= CNT_W'(WIN_RST);
            r_pos       <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_sumsq     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wen) begin
                r_window <= win_sat[CNT_W-1:0];
                r_pos    <= '0;
                r_fill   <= '0;
                r_sum    <= '0;
                r_sumsq  <= '0;
            end else begin
                if (r_state == S_READ) begin
                    r_pos  <= pos_next;
                    r_fill <= fill_next;
                end
                if (r_state == S_ACCUM) begin
                    r_sum   <= r_sum - SUM_W'(r_old) + SUM_W'(r_x);
                    r_sumsq <= r_sumsq - SQ_W'(r_sq_old) + SQ_W'(r_sq_new);
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x <= $signed(i_s_axis_tdata[SAMPLE_BITS-1:0]);
        end
        if (r_state == S_READ) begin
            r_old    <= old_smp;
            r_sq_old <= $unsigned(sq_old_s);
            r_sq_new <= $unsigned(sq_new_s);
        end
        if (r_state == S_MUL) begin
            r_a     <= a_prod;
            r_b     <= b_prod;
            r_small <= (r_fill < CNT_W'(2));
        end
        if (r_state == S_DIFF) begin
            r_rad <= R_W'(diff) << FRAC_SHIFT;
        end
        if (out_load) begin
            r_out_std  <= r_small ? '0 : std_sat;
            r_out_held <= held_ext[HELD_W-1:0];
        end
    end

    assign o_s_axis_tready = in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TD_W'({r_out_held, r_out_std});

    // ---------------- assertions ----------------
    a_fill_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_window)
        else $error("fill count beyond window length");

    a_pos_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_pos) < r_window)
        else $error("write position outside window");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(sq_stat.busy && dv_stat.busy))
        else $error("root and divide units busy together");

    a_accept_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (!sq_stat.busy && !dv_stat.busy))
        else $error("item accepted while an arithmetic unit is busy");

    a_load_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_m_axis_tvalid)
        else $error("result register not loaded");

endmodule

FILE: sv/swsd_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module swsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/swsd_isqrt.sv
`timescale 1ns / 1ps
// Iterative integer square root, two radicand bits per cycle (digit by digit).
// Depends on swsd_pkg for the unit status struct.
module swsd_isqrt #(
    parameter int RAD_W = 66
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [RAD_W-1:0]        i_rad,
    output swsd_pkg::t_unit_stat    o_stat,
    output logic [RAD_W/2-1:0]      o_root
);
    import swsd_pkg::*;

    localparam int ROOT_W = RAD_W / 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic              take;

    // bring down the next two radicand bits and try root*4+1
    assign rem_sh = {r_rem[ROOT_W-1:0], r_rad[RAD_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CNT_W'(ROOT_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rad  <= r_rad << 2;
                r_rem  <= take ? (rem_sh - trial) : rem_sh;
                r_root <= {r_root[ROOT_W-2:0], take};
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_root;

endmodule

FILE: sv/swsd_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle; remainder is discarded.
// Depends on swsd_pkg for the unit status struct.
module swsd_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 9
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [NUM_W-1:0]        i_num,
    input  logic [DEN_W-1:0]        i_den,
    output swsd_pkg::t_unit_stat    o_stat,
    output logic [NUM_W-1:0]        o_quot
);
    import swsd_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_diff;
    logic             take;

    assign rem_sh   = {r_rem, r_num[NUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_den};
    assign take     = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quot <= '0;
                r_cnt  <= CNT_W'(NUM_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num  <= r_num << 1;
                r_rem  <= take ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                r_quot <= {r_quot[NUM_W-2:0], take};
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule
